// ----- hdl/lsnms_pkg.sv -----
// Package for the line segment filter and suppression block.
// Holds sizes, register indexes and shared types; no dependencies.
`timescale 1ns / 1ps
package lsnms_pkg;
    localparam int LINE_SLOTS = 64;
    localparam int IDX_W      = $clog2(LINE_SLOTS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [1:0] REG_IMAGE_SIZE  = 2'd0;
    localparam logic [1:0] REG_SCORE_THR   = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd2;
    localparam logic [1:0] REG_BORDER      = 2'd3;

    typedef struct packed {
        logic [15:0] ey;
        logic [15:0] ex;
        logic [15:0] sy;
        logic [15:0] sx;
    } t_line;
endpackage

// ----- hdl/lsnms_isqrt.sv -----
// Iterative floor square root of a 34-bit value, two input bits per cycle.
// Standalone; o_done flags the cycle in which the result is ready.
`timescale 1ns / 1ps
module lsnms_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [33:0] i_val,
    output logic        o_done,
    output logic [16:0] o_root
);
    logic [33:0] r_val, n_val;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_root, n_root;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [18:0] rem_sh, trial, diff;

    always_comb begin
        n_val = r_val; n_rem = r_rem; n_root = r_root; n_cnt = r_cnt; n_busy = r_busy;
        n_done = 1'b0;
        // bring down the next bit pair and try appending a one to the root
        rem_sh = {r_rem, r_val[33:32]};
        trial  = {r_root, 2'b01};
        diff   = rem_sh - trial;
        if (i_go) begin
            n_val = i_val; n_rem = '0; n_root = '0; n_cnt = 5'd17; n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[31:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = diff[16:0];
                n_root = {r_root[15:0], 1'b1};
            end else begin
                n_rem  = rem_sh[16:0];
                n_root = {r_root[15:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_val <= n_val; r_rem <= n_rem; r_root <= n_root;
    end
    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- hdl/line_segment_filter_nms.sv -----
// Line segment filter and greedy suppression, top level.
// Uses lsnms_pkg and lsnms_isqrt.
`timescale 1ns / 1ps
// Queries load one per cycle while busy is low: each transfer is scaled, filtered and,
// if it survives, written to the line store in the cycle after. The query flagged
// i_in_last raises busy and starts suppression. Each round scans all n stored lines
// for the longest unprocessed one (states S_SCAN and S_SCANW per line), fetches it,
// then walks the store: each still kept, unprocessed line gets one comparison made
// of four serial square roots, and any other line is skipped; the square roots set
// the suppression time. Results then leave in arrival order, at most one per pass
// through S_OUTRD and S_OUT, each marked by o_valid for one cycle; the receiver
// cannot stall, so be ready. A frame with no kept line gives one result flagged
// o_empty_res. busy falls as the final result appears, and the next frame may start
// loading then.
module line_segment_filter_nms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_score,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    input  logic        i_in_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_out_start_x,
    output logic [15:0] o_out_start_y,
    output logic [15:0] o_out_end_x,
    output logic [15:0] o_out_end_y,
    output logic        o_out_last,
    output logic        o_empty_res
);
    import lsnms_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
        S_CMPRD = 4'd3, S_CMPW = 4'd4, S_SQ = 4'd5, S_SQW = 4'd6, S_DEC = 4'd7,
        S_OUTRD = 4'd8, S_OUT = 4'd9, S_EMPTY = 4'd10, S_ROOT = 4'd11;

    // square root steps of one comparison
    localparam logic [1:0] K_LEN_A = 2'd0, K_LEN_B = 2'd1, K_D_START = 2'd2,
        K_D_END = 2'd3;

    logic [10:0] r_image_size;
    logic [15:0] r_score_thr, r_min_len;
    logic [7:0]  r_border;

    // --- configuration writes, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 11'd512; r_score_thr <= 16'd32768;
            r_min_len <= 16'd640; r_border <= 8'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data[10:0];
                REG_SCORE_THR:  r_score_thr  <= i_cfg_data;
                REG_MIN_LENGTH: r_min_len    <= i_cfg_data;
                REG_BORDER:     r_border     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // --- input filter (scale, score, length, border), registered once
    function automatic logic [15:0] f_scale(input logic [15:0] f, input logic [10:0] s);
        logic [26:0] p;
        p = f * s;
        f_scale = (p[26:10] > 17'hFFFF) ? 16'hFFFF : p[25:10];
    endfunction
    function automatic logic [15:0] f_adiff(input logic [15:0] a, input logic [15:0] b);
        f_adiff = (a > b) ? a - b : b - a;
    endfunction

    logic        acc;
    t_line       in_line;
    logic [15:0] r_dx, r_dy;
    logic        r_pv, r_plast, r_pok;
    t_line       r_pline;
    logic [17:0] lo_b, hi_b;
    logic        ins;

    assign acc = start && !busy;
    always_comb begin
        in_line.sx = f_scale(i_start_x, r_image_size);
        in_line.sy = f_scale(i_start_y, r_image_size);
        in_line.ex = f_scale(i_end_x, r_image_size);
        in_line.ey = f_scale(i_end_y, r_image_size);
        lo_b = {4'd0, r_border, 6'd0};
        hi_b = ({7'd0, r_image_size} - {10'd0, r_border}) << 6;
        ins = ({2'd0, in_line.sx} > lo_b) && ({2'd0, in_line.sx} < hi_b) &&
              ({2'd0, in_line.sy} > lo_b) && ({2'd0, in_line.sy} < hi_b) &&
              ({2'd0, in_line.ex} > lo_b) && ({2'd0, in_line.ex} < hi_b) &&
              ({2'd0, in_line.ey} > lo_b) && ({2'd0, in_line.ey} < hi_b) &&
              !hi_b[17] && ({7'd0, r_image_size} > {10'd0, r_border});
    end

    // length squares come from registered differences
    logic [33:0] p_len_sq;
    logic [31:0] ml_sq;
    assign p_len_sq = r_dx * r_dx + r_dy * r_dy;
    assign ml_sq = r_min_len * r_min_len;

    logic [3:0]       r_st;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i, r_j, r_kept, r_emit, r_sup;
    logic [IDX_W-1:0] r_best;
    logic [33:0]      r_best_len;
    logic             r_found;
    logic [LINE_SLOTS-1:0] r_keep, r_proc;

    // --- line store, one write port one read port, registered read
    t_line mem [LINE_SLOTS];
    t_line r_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_cnt[IDX_W-1:0]] <= r_pline;
        r_rd <= mem[rd_addr];
    end
    assign wr_en = r_pv && r_pok && (r_cnt < CNT_W'(LINE_SLOTS)) &&
                   (p_len_sq >= {2'd0, ml_sq});

    // --- square root operand selection and sequencing
    t_line      r_a;
    logic [1:0] r_k;
    logic [16:0] r_r0, r_r1, r_r2;
    logic [33:0] sq_in;
    logic        sq_go, sq_done;
    logic [16:0] sq_root;
    logic [15:0] ax, ay, bx, by;
    always_comb begin
        unique case (r_k)
            K_LEN_A: begin ax = r_a.sx; ay = r_a.sy; bx = r_a.ex; by = r_a.ey; end
            K_LEN_B: begin ax = r_rd.sx; ay = r_rd.sy; bx = r_rd.ex; by = r_rd.ey; end
            K_D_START: begin ax = r_a.sx; ay = r_a.sy; bx = r_rd.sx; by = r_rd.sy; end
            default: begin ax = r_a.ex; ay = r_a.ey; bx = r_rd.ex; by = r_rd.ey; end
        endcase
    end
    logic [15:0] r_sdx, r_sdy;
    assign sq_in = r_sdx * r_sdx + r_sdy * r_sdy;
    assign sq_go = (r_st == S_SQ);

    lsnms_isqrt u_sqrt (.i_clk, .i_rst_n, .i_go(sq_go), .i_val(sq_in),
                        .o_done(sq_done), .o_root(sq_root));

    logic [17:0] sum_len;
    logic [18:0] two_d;
    assign sum_len = {1'b0, r_r0} + {1'b0, r_r1};
    assign two_d   = ({2'b00, r_r2} + {2'b00, sq_root}) << 1;

    logic [33:0] rd_len;
    assign rd_len = {18'd0, f_adiff(r_rd.sx, r_rd.ex)} * f_adiff(r_rd.sx, r_rd.ex) +
                    {18'd0, f_adiff(r_rd.sy, r_rd.ey)} * f_adiff(r_rd.sy, r_rd.ey);

    assign rd_addr = r_i[IDX_W-1:0];

    // --- result registers
    logic  r_valid, r_res_last, r_res_empty;
    t_line r_res;
    logic  emit_now, frame_done;
    assign emit_now   = (r_st == S_EMPTY) || (r_st == S_OUT && r_keep[r_i[IDX_W-1:0]]);
    assign frame_done = (r_st == S_EMPTY) ||
                        (r_st == S_OUT && r_keep[r_i[IDX_W-1:0]] && (r_emit + 1'b1 == r_kept));

    assign o_valid       = r_valid;
    assign o_out_start_x = r_res.sx;
    assign o_out_start_y = r_res.sy;
    assign o_out_end_x   = r_res.ex;
    assign o_out_end_y   = r_res.ey;
    assign o_out_last    = r_res_last;
    assign o_empty_res   = r_res_empty;

    assign busy = (r_st != S_LOAD) || (r_pv && r_plast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_pv <= 1'b0; r_cnt <= '0; r_keep <= '1; r_proc <= '0;
            r_sup <= '0; r_valid <= 1'b0;
        end else begin
            r_valid <= emit_now;
            r_pv <= acc;
            // clear the store count at frame end, advance it on each stored line
            if (frame_done) r_cnt <= '0;
            else if (wr_en) r_cnt <= r_cnt + 1'b1;
            unique case (r_st)
                S_LOAD: if (r_pv && r_plast) begin
                    r_st <= S_SCAN; r_i <= '0; r_found <= 1'b0;
                end
                // find longest unprocessed, ties to earlier
                S_SCAN: begin
                    if (r_i == r_cnt) begin
                        if (!r_found) begin
                            r_st <= S_OUTRD; r_i <= '0; r_emit <= '0;
                            r_kept <= r_cnt - r_sup;
                        end else begin
                            r_proc[r_best] <= 1'b1;
                            if (r_keep[r_best]) begin
                                r_i <= {1'b0, r_best}; r_st <= S_CMPRD;
                            end else begin
                                r_i <= '0; r_found <= 1'b0; r_st <= S_SCAN;
                            end
                        end
                    end else r_st <= S_SCANW;
                end
                S_SCANW: begin
                    if (!r_proc[r_i[IDX_W-1:0]] && (!r_found || rd_len > r_best_len)) begin
                        r_found <= 1'b1; r_best <= r_i[IDX_W-1:0]; r_best_len <= rd_len;
                    end
                    r_i <= r_i + 1'b1; r_st <= S_SCAN;
                end
                // r_i points at best: fetch it into r_a, then sweep the store
                S_CMPRD: r_st <= S_CMPW;
                S_CMPW: begin
                    r_a <= r_rd; r_j <= '0; r_k <= K_LEN_A; r_i <= '0; r_st <= S_DEC;
                end
                S_DEC: begin
                    if (r_i == r_cnt) begin
                        r_i <= '0; r_found <= 1'b0; r_st <= S_SCAN;
                    end else if (r_proc[r_i[IDX_W-1:0]] || !r_keep[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_k <= K_LEN_A; r_st <= S_SQW;
                    end
                end
                // r_rd now holds line i (read address = r_i)
                S_SQW: begin
                    r_sdx <= f_adiff(ax, bx); r_sdy <= f_adiff(ay, by); r_st <= S_SQ;
                end
                S_SQ: r_st <= S_ROOT;
                S_ROOT: if (sq_done) begin
                    unique case (r_k)
                        K_LEN_A:   r_r0 <= sq_root;
                        K_LEN_B:   r_r1 <= sq_root;
                        K_D_START: r_r2 <= sq_root;
                        default: begin
                            // drop line i when the endpoints sit close relative to the lengths
                            if (sum_len != 18'd0 && two_d < {1'b0, sum_len}) begin
                                r_keep[r_i[IDX_W-1:0]] <= 1'b0;
                                r_sup <= r_sup + 1'b1;
                            end
                        end
                    endcase
                    if (r_k == K_D_END) begin
                        r_i <= r_i + 1'b1; r_st <= S_DEC;
                    end else begin
                        r_k <= r_k + 1'b1; r_st <= S_SQW;
                    end
                end
                // emit kept lines in arrival order
                S_OUTRD: begin
                    if (r_kept == '0) r_st <= S_EMPTY;
                    else if (r_i == r_cnt) r_st <= S_EMPTY;
                    else r_st <= S_OUT;
                end
                S_OUT: begin
                    if (r_keep[r_i[IDX_W-1:0]]) r_emit <= r_emit + 1'b1;
                    r_i <= r_i + 1'b1;
                    if (frame_done) begin
                        r_st <= S_LOAD; r_keep <= '1; r_proc <= '0; r_sup <= '0;
                    end else r_st <= S_OUTRD;
                end
                S_EMPTY: begin
                    r_st <= S_LOAD; r_keep <= '1; r_proc <= '0; r_sup <= '0;
                end
                default: r_st <= S_LOAD;
            endcase
        end
        // hold result fields for the cycle of the strobe
        if (r_st == S_EMPTY) begin
            r_res <= '0; r_res_empty <= 1'b1; r_res_last <= 1'b1;
        end else if (emit_now) begin
            r_res <= r_rd; r_res_empty <= 1'b0;
            r_res_last <= (r_emit + 1'b1 == r_kept);
        end
        r_pline <= in_line;
        r_plast <= i_in_last;
        r_pok <= (i_score >= r_score_thr) && ins;
        r_dx <= f_adiff(in_line.sx, in_line.ex);
        r_dy <= f_adiff(in_line.sy, in_line.ey);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_out_last) else $error("empty result not last");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LINE_SLOTS)) else $error("store count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |-> busy) else $error("result outside frame");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sup <= r_cnt) else $error("suppressed count above stored count");
endmodule

// ----- tb/line_segment_filter_nms_tb.sv -----
// Testbench for line_segment_filter_nms: filtering, greedy suppression and output order.
// Depends on lsnms_pkg and the RTL top level; predicts results with its own model.
`timescale 1ns / 1ps
module line_segment_filter_nms_tb;
    import lsnms_pkg::*;

    typedef struct {
        logic [15:0] sx, sy, ex, ey;
        logic        last, empty;
    } t_kept;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_score = '0, i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic        i_in_last = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic [15:0] o_out_start_x, o_out_start_y, o_out_end_x, o_out_end_y;
    logic        o_out_last, o_empty_res;

    line_segment_filter_nms dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow registers and frame state of the predictor
    int unsigned img_size, score_thr, min_len, margin;
    logic [15:0] frame_lines [LINE_SLOTS][4];
    int unsigned frame_count;
    t_kept       kept_queue [$];
    int unsigned mismatches;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned dist_sq(int unsigned ax, int unsigned ay,
                                                int unsigned bx, int unsigned by);
        longint unsigned dx, dy;
        dx = ax > bx ? ax - bx : bx - ax;
        dy = ay > by ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    function automatic int unsigned to_pixels(logic [15:0] f);
        longint unsigned v;
        v = (longint'(f) * img_size) >> 10;
        return v > 65535 ? 65535 : int'(v);
    endfunction

    function automatic bit within_border(int unsigned c);
        longint lo, hi;
        lo = longint'(margin) * 64;
        hi = (longint'(img_size) - longint'(margin)) * 64;
        return longint'(c) > lo && longint'(c) < hi;
    endfunction

    function automatic longint unsigned seg_len_sq(int i);
        return dist_sq(frame_lines[i][0], frame_lines[i][1],
                       frame_lines[i][2], frame_lines[i][3]);
    endfunction

    function automatic bit segments_overlap(int a, int b);
        longint unsigned la, lb, ds, de;
        la = floor_sqrt(seg_len_sq(a));
        lb = floor_sqrt(seg_len_sq(b));
        ds = floor_sqrt(dist_sq(frame_lines[a][0], frame_lines[a][1],
                                frame_lines[b][0], frame_lines[b][1]));
        de = floor_sqrt(dist_sq(frame_lines[a][2], frame_lines[a][3],
                                frame_lines[b][2], frame_lines[b][3]));
        return (la + lb) > 0 && 2 * (ds + de) < la + lb;
    endfunction

    // Filter one query; on the last query run suppression and queue the kept lines or an empty result
    function automatic void predict_query(logic [15:0] sc, logic [15:0] qsx, logic [15:0] qsy,
                                          logic [15:0] qex, logic [15:0] qey, logic lst);
        int unsigned px, py, qx, qy;
        bit keep [LINE_SLOTS];
        bit done [LINE_SLOTS];
        int best, nkept, emitted;
        longint unsigned best_len, l;
        t_kept k;
        px = to_pixels(qsx); py = to_pixels(qsy);
        qx = to_pixels(qex); qy = to_pixels(qey);
        if (sc >= score_thr && dist_sq(px, py, qx, qy) >= longint'(min_len) * min_len &&
            within_border(px) && within_border(py) && within_border(qx) &&
            within_border(qy) && frame_count < LINE_SLOTS) begin
            frame_lines[frame_count] = '{px[15:0], py[15:0], qx[15:0], qy[15:0]};
            frame_count++;
        end
        if (!lst) return;
        for (int i = 0; i < LINE_SLOTS; i++) begin
            keep[i] = 1'b1;
            done[i] = 1'b0;
        end
        for (int r = 0; r < frame_count; r++) begin
            best = -1;
            best_len = 0;
            for (int i = 0; i < frame_count; i++) begin
                if (done[i]) continue;
                l = seg_len_sq(i);
                if (best < 0 || l > best_len) begin
                    best = i;
                    best_len = l;
                end
            end
            if (best < 0) break;
            done[best] = 1'b1;
            if (!keep[best]) continue;
            for (int i = 0; i < frame_count; i++)
                if (!done[i] && keep[i] && segments_overlap(best, i)) keep[i] = 1'b0;
        end
        nkept = 0;
        for (int i = 0; i < frame_count; i++) nkept += keep[i];
        if (nkept == 0) begin
            k = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
            kept_queue.insert(kept_queue.size(), k);
        end
        emitted = 0;
        for (int i = 0; i < frame_count; i++) begin
            if (!keep[i]) continue;
            emitted++;
            k = '{frame_lines[i][0], frame_lines[i][1], frame_lines[i][2], frame_lines[i][3],
                  emitted == nkept, 1'b0};
            kept_queue.insert(kept_queue.size(), k);
        end
        frame_count = 0;
    endfunction

    // Compare every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_kept e;
        if (i_rst_n && o_valid) begin
            if (kept_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: exp none got %h %h %h %h l%b e%b",
                             $realtime, o_out_start_x, o_out_start_y, o_out_end_x,
                             o_out_end_y, o_out_last, o_empty_res);
            end else begin
                e = kept_queue.pop_front();
                if (o_out_start_x !== e.sx || o_out_start_y !== e.sy || o_out_end_x !== e.ex ||
                    o_out_end_y !== e.ey || o_out_last !== e.last || o_empty_res !== e.empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h l%b e%b got %h %h %h %h l%b e%b",
                                 e.sx, e.sy, e.ex, e.ey, e.last, e.empty,
                                 o_out_start_x, o_out_start_y, o_out_end_x, o_out_end_y,
                                 o_out_last, o_empty_res);
                end
            end
        end
    end

    // Hold the query until a transfer, then predict it
    task automatic send_query(logic [15:0] sc, logic [15:0] qsx, logic [15:0] qsy,
                              logic [15:0] qex, logic [15:0] qey, logic lst);
        start <= 1'b1;
        i_score <= sc; i_start_x <= qsx; i_start_y <= qsy;
        i_end_x <= qex; i_end_y <= qey; i_in_last <= lst;
        do @(posedge i_clk); while (busy);
        predict_query(sc, qsx, qsy, qex, qey, lst);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (kept_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write one register; only call while the block is idle, the caller drops valid
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IMAGE_SIZE: img_size = val[10:0];
            REG_SCORE_THR:  score_thr = val;
            REG_MIN_LENGTH: min_len = val;
            REG_BORDER:     margin = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned sz, int unsigned thr, int unsigned ml, int unsigned bm);
        write_reg(REG_IMAGE_SIZE, sz[15:0]);
        write_reg(REG_SCORE_THR, thr[15:0]);
        write_reg(REG_MIN_LENGTH, ml[15:0]);
        write_reg(REG_BORDER, bm[15:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // Directed: field extremes, empty frame, overlap pair, zero length, tiny and large margin, saturation
    task automatic test_directed;
        set_config(512, 0, 0, 0);
        send_query(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        send_query(16'h0000, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 1'b0);
        send_query(16'h8000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b0);
        send_query(16'h8000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b1);
        drain();
        set_config(512, 32768, 640, 4);
        // Near-duplicate lines: the shorter one goes
        send_query(16'hFFFF, 16'h2000, 16'h2000, 16'h6000, 16'h6000, 1'b0);
        send_query(16'hC000, 16'h2010, 16'h2000, 16'h5F00, 16'h6000, 1'b0);
        send_query(16'h1000, 16'h3000, 16'h3000, 16'h9000, 16'h9000, 1'b0);
        send_query(16'h9000, 16'hA000, 16'h1000, 16'h1100, 16'hA000, 1'b1);
        drain();
        // Nothing survives the score threshold: empty result
        set_config(1024, 65535, 65535, 255);
        send_query(16'hFFFE, 16'h8000, 16'h8000, 16'h9000, 16'h9000, 1'b1);
        drain();
        // Margin at least half the size drops everything
        set_config(8, 0, 0, 4);
        send_query(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        drain();
        // Oversized image saturates coordinates
        set_config(2047, 0, 0, 0);
        send_query(16'h8000, 16'h0100, 16'h0200, 16'hFFFF, 16'h7000, 1'b1);
        drain();
    endtask

    // Random frames in bursts; small frames mostly, a few large ones that may overfill the store
    task automatic test_random(int frames);
        int n;
        logic [15:0] bx, by;
        for (int f = 0; f < frames; f++) begin
            case ($urandom_range(0, 3))
                0: set_config($urandom_range(8, 1024), $urandom_range(0, 65535),
                              $urandom_range(0, 2000), $urandom_range(0, 40));
                1: set_config(512, $urandom_range(0, 32768), $urandom_range(0, 800),
                              $urandom_range(0, 8));
                default: ;
            endcase
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            bx = $urandom; by = $urandom;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
                if ($urandom_range(0, 1))
                    send_query($urandom, bx + $urandom_range(0, 2000), by + $urandom_range(0, 2000),
                               bx + 16'h3000 + $urandom_range(0, 2000), by + $urandom_range(0, 4000),
                               i == n - 1);
                else
                    send_query($urandom, $urandom, $urandom, $urandom, $urandom, i == n - 1);
            end
            // Pause until every expected result has come
            drain();
        end
    endtask

    initial begin
        img_size = 512; score_thr = 32768; min_len = 640; margin = 4;
        frame_count = 0; mismatches = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(24);
        drain();
        if (mismatches == 0 && kept_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #100000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
